/* design/fat12_pkg.sv */
// Shared types, codes and constants for the FAT12 cluster table engine.
`default_nettype none
package fat12_pkg;

	localparam int TABLE_DEPTH_DEF = 8192;
	// Highest byte offset an entry access can touch (second byte of cluster 4095).
	localparam int MAX_ENTRY_OFF = 6143;

	localparam logic [11:0] ENTRY_MASK     = 12'hFFF;
	localparam logic [15:0] HI_NIBBLE_MASK = 16'hF000;
	localparam logic [15:0] LO_NIBBLE_MASK = 16'h000F;
	localparam logic [11:0] EOC_MIN        = 12'hFF8;
	localparam logic [11:0] FIRST_CLUSTER  = 12'd2;

	typedef logic [2:0] op_t;
	localparam op_t OP_LOAD_BYTE  = 3'd0;
	localparam op_t OP_READ_BYTE  = 3'd1;
	localparam op_t OP_READ_ENTRY = 3'd2;
	localparam op_t OP_WRITE_ENTRY = 3'd3;
	localparam op_t OP_FIND_FREE  = 3'd4;
	localparam op_t OP_FREE_CHAIN = 3'd5;

	localparam logic [1:0] CFG_CLUSTER_COUNT = 2'd0;
	localparam logic [1:0] CFG_DATA_START    = 2'd1;
	localparam logic [1:0] CFG_SECT_PER_CLUS = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NO_FREE = 2'd1;
	localparam logic [1:0] ST_LIMIT   = 2'd2;

	localparam logic [1:0] ADDR_PORT_BYTE = 2'd0;
	localparam logic [1:0] ADDR_PORT_A0   = 2'd1;
	localparam logic [1:0] ADDR_A0        = 2'd2;
	localparam logic [1:0] ADDR_A1        = 2'd3;

	localparam logic [1:0] WR_PORT_BYTE = 2'd0;
	localparam logic [1:0] WR_A0_NEW    = 2'd1;
	localparam logic [1:0] WR_A1_NEW    = 2'd2;

	localparam logic [2:0] RES_ZERO    = 3'd0;
	localparam logic [2:0] RES_BYTE    = 3'd1;
	localparam logic [2:0] RES_ENTRY   = 3'd2;
	localparam logic [2:0] RES_FOUND   = 3'd3;
	localparam logic [2:0] RES_NO_FREE = 3'd4;
	localparam logic [2:0] RES_LIMIT   = 3'd5;

	typedef struct packed {
		logic       ld_port;
		logic       ld_search;
		logic       search_adv;
		logic       chain_next;
		logic       rd_en;
		logic [1:0] addr_sel;
		logic       wr_en;
		logic [1:0] wr_sel;
		logic       put_zero;
		logic       cap_lo;
		logic       cap_word;
		logic       res_load;
		logic [2:0] res_kind;
	} ctl_cmd_t;

	typedef struct packed {
		logic c_lt2;
		logic steps_ge;
		logic srch_valid;
		logic entry_zero;
		logic eoc;
	} ctl_sts_t;

endpackage
`default_nettype wire

/* design/fat12_ctrl.sv */
// Operation sequencer for the FAT12 cluster table engine.
`default_nettype none
module fat12_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire fat12_pkg::op_t      op,
	input  wire fat12_pkg::ctl_sts_t sts,
	output fat12_pkg::ctl_cmd_t      cmd,
	output logic                     busy
);
	import fat12_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RB   = 3'd1;
	localparam logic [2:0] S_E1   = 3'd2;
	localparam logic [2:0] S_E2   = 3'd3;
	localparam logic [2:0] S_W1   = 3'd4;
	localparam logic [2:0] S_SCHK = 3'd5;
	localparam logic [2:0] S_FCHK = 3'd6;

	logic [2:0] state_q, state_nx;
	op_t        op_q;

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_LOAD_BYTE;
		end else begin
			state_q <= state_nx;
			if (state_q == S_IDLE && start) begin
				op_q <= op;
			end
		end
	end

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.ld_port = 1'b1;
					unique case (op)
						OP_LOAD_BYTE: begin
							cmd.wr_en    = 1'b1;
							cmd.wr_sel   = WR_PORT_BYTE;
							cmd.res_load = 1'b1;
							cmd.res_kind = RES_ZERO;
						end
						OP_READ_BYTE: begin
							cmd.rd_en    = 1'b1;
							cmd.addr_sel = ADDR_PORT_BYTE;
							state_nx     = S_RB;
						end
						OP_READ_ENTRY, OP_WRITE_ENTRY: begin
							cmd.rd_en    = 1'b1;
							cmd.addr_sel = ADDR_PORT_A0;
							state_nx     = S_E1;
						end
						OP_FIND_FREE: begin
							cmd.ld_search = 1'b1;
							state_nx      = S_SCHK;
						end
						OP_FREE_CHAIN: begin
							state_nx = S_FCHK;
						end
						default: begin
							cmd.res_load = 1'b1;
							cmd.res_kind = RES_ZERO;
						end
					endcase
				end
			end
			S_RB: begin
				cmd.res_load = 1'b1;
				cmd.res_kind = RES_BYTE;
				state_nx     = S_IDLE;
			end
			S_E1: begin
				cmd.rd_en    = 1'b1;
				cmd.addr_sel = ADDR_A1;
				cmd.cap_lo   = 1'b1;
				state_nx     = S_E2;
			end
			S_E2: begin
				cmd.cap_word = 1'b1;
				cmd.put_zero = (op_q == OP_FREE_CHAIN);
				state_nx     = S_IDLE;
				unique case (op_q)
					OP_READ_ENTRY: begin
						cmd.res_load = 1'b1;
						cmd.res_kind = RES_ENTRY;
					end
					OP_WRITE_ENTRY, OP_FREE_CHAIN: begin
						cmd.wr_en  = 1'b1;
						cmd.wr_sel = WR_A0_NEW;
						state_nx   = S_W1;
					end
					OP_FIND_FREE: begin
						if (sts.entry_zero) begin
							cmd.res_load = 1'b1;
							cmd.res_kind = RES_FOUND;
						end else begin
							cmd.search_adv = 1'b1;
							state_nx       = S_SCHK;
						end
					end
					default: begin
						state_nx = S_IDLE;
					end
				endcase
			end
			S_W1: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = WR_A1_NEW;
				if (op_q == OP_FREE_CHAIN && !sts.eoc) begin
					cmd.chain_next = 1'b1;
					state_nx       = S_FCHK;
				end else begin
					cmd.res_load = 1'b1;
					cmd.res_kind = RES_ZERO;
					state_nx     = S_IDLE;
				end
			end
			S_SCHK: begin
				if (!sts.srch_valid) begin
					cmd.res_load = 1'b1;
					cmd.res_kind = RES_NO_FREE;
					state_nx     = S_IDLE;
				end else begin
					cmd.rd_en    = 1'b1;
					cmd.addr_sel = ADDR_A0;
					state_nx     = S_E1;
				end
			end
			S_FCHK: begin
				if (sts.c_lt2) begin
					cmd.res_load = 1'b1;
					cmd.res_kind = RES_ZERO;
					state_nx     = S_IDLE;
				end else if (sts.steps_ge) begin
					cmd.res_load = 1'b1;
					cmd.res_kind = RES_LIMIT;
					state_nx     = S_IDLE;
				end else begin
					cmd.rd_en    = 1'b1;
					cmd.addr_sel = ADDR_A0;
					state_nx     = S_E1;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

/* design/fat12_datapath.sv */
// Table memory, configuration registers, address and entry datapath.
`default_nettype none
module fat12_datapath #(
	parameter int TABLE_DEPTH = fat12_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [15:0]         cfg_data,
	input  wire logic [12:0]         byte_index,
	input  wire logic [7:0]          byte_data,
	input  wire logic [11:0]         cluster,
	input  wire logic [11:0]         write_value,
	input  wire fat12_pkg::ctl_cmd_t cmd,
	output fat12_pkg::ctl_sts_t      sts,
	output logic [11:0]              entry_value,
	output logic [15:0]              sector_address,
	output logic [7:0]               byte_out,
	output logic [1:0]               status,
	output logic                     done
);
	import fat12_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int WRAP_STEPS = MAX_ENTRY_OFF / TABLE_DEPTH;
	localparam logic [13:0] DEPTH_W = 14'(TABLE_DEPTH);

	// Byte offset of an entry (or the byte after it), folded into the table.
	function automatic logic [AW-1:0] entry_addr(input logic [11:0] c, input logic hi);
		logic [13:0] x;
		x = {2'b00, c} + {3'b000, c[11:1]} + {13'd0, hi};
		for (int i = 0; i < WRAP_STEPS; i++) begin
			if (x >= DEPTH_W) begin
				x = x - DEPTH_W;
			end
		end
		return x[AW-1:0];
	endfunction

	logic [7:0]  mem [TABLE_DEPTH];
	logic [7:0]  rdata_q;
	logic [11:0] cc_q;
	logic [15:0] dss_q;
	logic [7:0]  spc_q;
	logic [11:0] c_q, start_q, steps_q, wv_q, entry_q;
	logic        phase_q, inrange_q;
	logic [7:0]  lo_q;
	logic [15:0] word_q, prod_q;
	logic [11:0] ev_q;
	logic [15:0] sa_q;
	logic [7:0]  bo_q;
	logic [1:0]  st_q;
	logic        done_q;

	logic [12:0]   bound_sum;
	logic [11:0]   bound, start_eff;
	logic          port_inrange;
	logic [AW-1:0] port_baddr, p_a0, c_a0, c_a1, raddr, waddr;
	logic [7:0]    wdata;
	logic          wr_go;
	logic [15:0]   word_now, put_now, sector_now, c_m2;
	logic [11:0]   entry_now, put_val;

	assign bound_sum    = {1'b0, cc_q} + 13'd1;
	assign bound        = bound_sum[12] ? ENTRY_MASK : bound_sum[11:0];
	assign start_eff    = (cluster < FIRST_CLUSTER) ? FIRST_CLUSTER : cluster;
	assign port_inrange = ({1'b0, byte_index} < DEPTH_W);
	assign port_baddr   = port_inrange ? byte_index[AW-1:0] : '0;
	assign p_a0         = entry_addr(cluster, 1'b0);
	assign c_a0         = entry_addr(c_q, 1'b0);
	assign c_a1         = entry_addr(c_q, 1'b1);

	assign word_now  = {rdata_q, lo_q};
	assign entry_now = c_q[0] ? word_now[15:4] : (word_now[11:0] & ENTRY_MASK);
	assign put_val   = cmd.put_zero ? 12'd0 : wv_q;
	assign put_now   = c_q[0] ? ((word_now & LO_NIBBLE_MASK) | {put_val, 4'h0})
	                          : ((word_now & HI_NIBBLE_MASK) | {4'h0, put_val});
	assign c_m2       = {4'h0, c_q} - {4'h0, FIRST_CLUSTER};
	assign sector_now = dss_q + prod_q;

	always_comb begin
		case (cmd.addr_sel)
			ADDR_PORT_BYTE: raddr = port_baddr;
			ADDR_PORT_A0:   raddr = p_a0;
			ADDR_A0:        raddr = c_a0;
			default:        raddr = c_a1;
		endcase
		case (cmd.wr_sel)
			WR_PORT_BYTE: begin
				waddr = port_baddr;
				wdata = byte_data;
				wr_go = cmd.wr_en && port_inrange;
			end
			WR_A0_NEW: begin
				waddr = c_a0;
				wdata = put_now[7:0];
				wr_go = cmd.wr_en;
			end
			default: begin
				waddr = c_a1;
				wdata = word_q[15:8];
				wr_go = cmd.wr_en;
			end
		endcase
	end

	always_comb begin
		sts.c_lt2      = (c_q < FIRST_CLUSTER);
		sts.steps_ge   = (steps_q >= cc_q);
		sts.srch_valid = phase_q ? ((c_q < start_q) && (c_q <= bound)) : (c_q <= bound);
		sts.entry_zero = (entry_now == 12'd0);
		sts.eoc        = (entry_q >= EOC_MIN);
	end

	always_ff @(posedge clk) begin
		if (wr_go) begin
			mem[waddr] <= wdata;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q   <= 12'd0;
			dss_q  <= 16'd0;
			spc_q  <= 8'd1;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.res_load;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_CLUSTER_COUNT: cc_q  <= cfg_data[11:0];
					CFG_DATA_START:    dss_q <= cfg_data;
					CFG_SECT_PER_CLUS: spc_q <= cfg_data[7:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= 16'(c_m2 * spc_q);
		if (cmd.ld_port) begin
			c_q       <= cluster;
			wv_q      <= write_value;
			inrange_q <= port_inrange;
			steps_q   <= 12'd0;
		end
		if (cmd.ld_search) begin
			start_q <= start_eff;
			if (start_eff > bound) begin
				phase_q <= 1'b1;
				c_q     <= FIRST_CLUSTER;
			end else begin
				phase_q <= 1'b0;
				c_q     <= start_eff;
			end
		end
		if (cmd.search_adv) begin
			if (!phase_q && c_q == bound) begin
				phase_q <= 1'b1;
				c_q     <= FIRST_CLUSTER;
			end else begin
				c_q <= c_q + 12'd1;
			end
		end
		if (cmd.chain_next) begin
			c_q     <= entry_q;
			steps_q <= steps_q + 12'd1;
		end
		if (cmd.cap_lo) begin
			lo_q <= rdata_q;
		end
		if (cmd.cap_word) begin
			word_q  <= put_now;
			entry_q <= entry_now;
		end
		if (cmd.res_load) begin
			ev_q <= 12'd0;
			sa_q <= 16'd0;
			bo_q <= 8'd0;
			st_q <= ST_OK;
			case (cmd.res_kind)
				RES_BYTE:    bo_q <= inrange_q ? rdata_q : 8'd0;
				RES_ENTRY: begin
					ev_q <= entry_now;
					sa_q <= sector_now;
				end
				RES_FOUND: begin
					ev_q <= c_q;
					sa_q <= sector_now;
				end
				RES_NO_FREE: st_q <= ST_NO_FREE;
				RES_LIMIT:   st_q <= ST_LIMIT;
				default: ;
			endcase
		end
	end

	assign entry_value    = ev_q;
	assign sector_address = sa_q;
	assign byte_out       = bo_q;
	assign status         = st_q;
	assign done           = done_q;

endmodule
`default_nettype wire

/* design/fat12_cluster_table_engine_top.sv */
// Top level of the FAT12 cluster table engine: sequencer plus datapath.
// Steps per request: load byte and unused codes finish in the idle state; read byte adds RB;
// read entry goes through E1 and E2; write entry adds W1; find free probes clusters through SCHK,
// E1 and E2; free chain repeats FCHK, E1, E2 and W1 per entry freed until a low link, end or cap.
// Each entry probe is two reads through the single table read port; no new request is taken while
// busy, and a load byte request can follow every cycle. The result strobe cannot be stalled.
// Reset clears the configuration registers (sectors per cluster to 1) and the sequencer; the
// table itself is not cleared and holds no defined data until bytes are loaded.
`default_nettype none
module fat12_cluster_table_engine_top #(
	// Number of table bytes; sizes the memory and the address wrap.
	parameter int TABLE_DEPTH = fat12_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	// Request handshake: a request is taken when start is high and busy is low.
	input  wire logic           start,
	output logic                busy,
	input  wire fat12_pkg::op_t op,
	input  wire logic [12:0]    byte_index,
	input  wire logic [7:0]     byte_data,
	input  wire logic [11:0]    cluster,
	input  wire logic [11:0]    write_value,
	// Configuration write port; the user must write it only while the engine is idle (not enforced).
	input  wire logic           cfg_we,
	input  wire logic [1:0]     cfg_index,
	input  wire logic [15:0]    cfg_data,
	// Result, valid for exactly one cycle while done is high.
	output logic                done,
	output logic [11:0]         entry_value,
	output logic [15:0]         sector_address,
	output logic [7:0]          byte_out,
	output logic [1:0]          status
);
	import fat12_pkg::*;

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	// The sequencer walks each operation through its read, modify and write steps and
	// decides from the status flags when a search or a chain walk is finished.
	fat12_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// The datapath owns the table memory, the configuration registers, the entry
	// packing logic, the sector address multiplier and the result registers.
	fat12_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.byte_index     (byte_index),
		.byte_data      (byte_data),
		.cluster        (cluster),
		.write_value    (write_value),
		.cmd            (cmd),
		.sts            (sts),
		.entry_value    (entry_value),
		.sector_address (sector_address),
		.byte_out       (byte_out),
		.status         (status),
		.done           (done)
	);

endmodule
`default_nettype wire

/* dv/fat12_cluster_table_engine_checker.sv */
// Checker for the FAT12 cluster table engine: predicts every result and compares it.
`timescale 1ns / 100ps
module fat12_cluster_table_engine_checker (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic           busy,
	input  wire fat12_pkg::op_t op,
	input  wire logic [12:0]    byte_index,
	input  wire logic [7:0]     byte_data,
	input  wire logic [11:0]    cluster,
	input  wire logic [11:0]    write_value,
	input  wire logic           cfg_we,
	input  wire logic [1:0]     cfg_index,
	input  wire logic [15:0]    cfg_data,
	input  wire logic           done,
	input  wire logic [11:0]    entry_value,
	input  wire logic [15:0]    sector_address,
	input  wire logic [7:0]     byte_out,
	input  wire logic [1:0]     status,
	output int unsigned         fail_count,
	output int unsigned         pending
);
	import fat12_pkg::*;

	localparam int DEPTH = TABLE_DEPTH_DEF;
	localparam int MAX_SHOWN = 10;

	typedef struct packed {
		logic [11:0] entry_value;
		logic [15:0] sector_address;
		logic [7:0]  byte_out;
		logic [1:0]  status;
	} table_result_t;

	table_result_t awaited_results[$];
	logic [7:0]    table_image [DEPTH];
	logic [11:0]   clus_count = '0;
	logic [15:0]   data_start = '0;
	logic [7:0]    sect_per_clus = 8'd1;
	int unsigned   bad_results = 0;

	initial fail_count = 0;
	initial pending = 0;

	function automatic logic [11:0] entry_at(input logic [11:0] c);
		int unsigned off;
		logic [15:0] w;
		off = (int'(c) * 3) / 2;
		w = {table_image[(off + 1) % DEPTH], table_image[off % DEPTH]};
		return c[0] ? w[15:4] : w[11:0];
	endfunction

	function automatic void entry_store(input logic [11:0] c, input logic [11:0] v);
		int unsigned off, a0, a1;
		logic [15:0] w;
		off = (int'(c) * 3) / 2;
		a0 = off % DEPTH;
		a1 = (off + 1) % DEPTH;
		w = {table_image[a1], table_image[a0]};
		if (c[0]) begin
			w = (w & LO_NIBBLE_MASK) | {v, 4'h0};
		end else begin
			w = (w & HI_NIBBLE_MASK) | {4'h0, v};
		end
		table_image[a0] = w[7:0];
		table_image[a1] = w[15:8];
	endfunction

	// Sector arithmetic wraps at 16 bits, so clusters 0 and 1 land just below the data start.
	function automatic logic [15:0] first_sector(input logic [11:0] c);
		logic [15:0] rel;
		rel = 16'(c) - 16'(FIRST_CLUSTER);
		return data_start + rel * 16'(sect_per_clus);
	endfunction

	function automatic logic [11:0] free_search(input logic [11:0] from);
		int unsigned bound, first, c;
		bound = int'(clus_count) + 1;
		if (bound > 4095) bound = 4095;
		first = (from < FIRST_CLUSTER) ? int'(FIRST_CLUSTER) : int'(from);
		for (c = first; c <= bound; c++)
			if (entry_at(12'(c)) == 12'd0) return 12'(c);
		for (c = FIRST_CLUSTER; c < first && c <= bound; c++)
			if (entry_at(12'(c)) == 12'd0) return 12'(c);
		return 12'd0;
	endfunction

	function automatic logic [1:0] chain_release(input logic [11:0] head);
		logic [11:0] c, link;
		int unsigned steps;
		c = head;
		steps = 0;
		while (c >= FIRST_CLUSTER) begin
			if (steps >= clus_count) return ST_LIMIT;
			link = entry_at(c);
			entry_store(c, 12'd0);
			steps++;
			if (link >= EOC_MIN) break;
			c = link;
		end
		return ST_OK;
	endfunction

	function automatic table_result_t expected_outcome(input op_t o, input logic [12:0] bi,
			input logic [7:0] bd, input logic [11:0] cl, input logic [11:0] wv);
		table_result_t r;
		r = '0;
		case (o)
			OP_LOAD_BYTE: if (bi < DEPTH) table_image[bi] = bd;
			OP_READ_BYTE: if (bi < DEPTH) r.byte_out = table_image[bi];
			OP_READ_ENTRY: begin
				r.entry_value = entry_at(cl);
				r.sector_address = first_sector(cl);
			end
			OP_WRITE_ENTRY: entry_store(cl, wv);
			OP_FIND_FREE: begin
				r.entry_value = free_search(cl);
				if (r.entry_value == 12'd0) r.status = ST_NO_FREE;
				else r.sector_address = first_sector(r.entry_value);
			end
			OP_FREE_CHAIN: r.status = chain_release(cl);
			default: ;
		endcase
		return r;
	endfunction

	// Results are compared before the request of the same edge is predicted, so a stray
	// strobe can never be matched against a request that was only just taken.
	always @(posedge clk or negedge arst_n) begin
		table_result_t want, got;
		if (!arst_n) begin
			awaited_results.delete();
			clus_count = '0;
			data_start = '0;
			sect_per_clus = 8'd1;
			pending <= 0;
		end else begin
			if (done) begin
				got = {entry_value, sector_address, byte_out, status};
				if (awaited_results.size() == 0) begin
					bad_results++;
					if (bad_results <= MAX_SHOWN)
						$display("%0t ns: unexpected result, entry %h sector %h byte %h status %0d",
							$time, got.entry_value, got.sector_address, got.byte_out, got.status);
				end else begin
					want = awaited_results.pop_front();
					if (got !== want) begin
						bad_results++;
						if (bad_results <= MAX_SHOWN)
							$display({"%0t ns: mismatch, expected entry %h sector %h byte %h status %0d,",
								" got entry %h sector %h byte %h status %0d"}, $time,
								want.entry_value, want.sector_address, want.byte_out, want.status,
								got.entry_value, got.sector_address, got.byte_out, got.status);
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_CLUSTER_COUNT: clus_count = cfg_data[11:0];
					CFG_DATA_START:    data_start = cfg_data;
					CFG_SECT_PER_CLUS: sect_per_clus = cfg_data[7:0];
					default: ;
				endcase
			end
			if (start && !busy)
				awaited_results.push_back(expected_outcome(op, byte_index, byte_data, cluster,
					write_value));
			pending <= awaited_results.size();
		end
		fail_count <= bad_results;
	end
endmodule

/* dv/fat12_cluster_table_engine_top_test.sv */
// Testbench top for the FAT12 cluster table engine: stimulus, clock, reset and verdict.
`timescale 1ns / 100ps
module fat12_cluster_table_engine_top_test;
	import fat12_pkg::*;

	// The two op codes the engine does not define; they must produce an all-zero result.
	localparam op_t OP_SPARE_A = 3'd6;
	localparam op_t OP_SPARE_B = 3'd7;
	localparam int NUM_PHASES = 11;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	op_t         op = OP_LOAD_BYTE;
	logic [12:0] byte_index = '0;
	logic [7:0]  byte_data = '0;
	logic [11:0] cluster = '0;
	logic [11:0] write_value = '0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = CFG_CLUSTER_COUNT;
	logic [15:0] cfg_data = '0;
	logic        busy;
	logic        done;
	logic [11:0] entry_value;
	logic [15:0] sector_address;
	logic [7:0]  byte_out;
	logic [1:0]  status;
	int unsigned fail_count;
	int unsigned pending;

	// Stimulus bookkeeping: the cluster count currently programmed, whether the sender
	// idles between requests in this phase, and a tally of what was sent.
	int unsigned cur_count = 0;
	int unsigned idle_mode = 0;
	int unsigned issued = 0;
	int unsigned settings_used = 0;
	int unsigned chains_built = 0;
	int unsigned op_tally [8] = '{default: 0};

	fat12_cluster_table_engine_top dut (.*);

	fat12_cluster_table_engine_checker table_check (.*);

	always #2 clk = ~clk;

	// Generous ceiling: far beyond a run where every chain walks the full cluster count.
	initial begin
		#20_000_000;
		$display("Run did not finish in time.");
		$display("TEST FAILED");
		$finish;
	end

	// Presents one request and returns at the edge where it is taken. Start stays high
	// when the next request follows without a gap, so it is never dropped and raised in
	// the same step.
	task automatic send_request(input op_t o, input logic [12:0] bi, input logic [7:0] bd,
			input logic [11:0] cl, input logic [11:0] wv);
		int unsigned gap;
		gap = (idle_mode == 0) ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		op <= o;
		byte_index <= bi;
		byte_data <= bd;
		cluster <= cl;
		write_value <= wv;
		do @(posedge clk); while (busy);
		op_tally[o]++;
		issued++;
	endtask

	// Holds off new requests until every predicted result has come back and the engine has gone quiet.
	task automatic wait_all_results();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0 || busy);
		repeat (4) @(posedge clk);
	endtask

	// Register writes happen only with the engine idle; all three are written each time.
	task automatic apply_settings(input int unsigned cc, input logic [15:0] ds,
			input int unsigned spc);
		wait_all_results();
		cfg_we <= 1'b1;
		cfg_index <= CFG_CLUSTER_COUNT;
		cfg_data <= 16'(cc);
		@(posedge clk);
		cfg_index <= CFG_DATA_START;
		cfg_data <= ds;
		@(posedge clk);
		cfg_index <= CFG_SECT_PER_CLUS;
		cfg_data <= 16'(spc);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		cur_count = cc;
		settings_used++;
	endtask

	// A cluster inside the searchable range; with a zero count a few low clusters are used.
	function automatic logic [11:0] pick_cluster();
		int unsigned hi;
		hi = (cur_count == 0) ? 9 : cur_count + 1;
		return 12'($urandom_range(2, hi));
	endfunction

	// Builds a linked chain with entry writes, ending either on an end-of-chain marker or on
	// a low link, then reads, frees and searches around it. Chains longer than the cluster
	// count run into the step limit. Repeated clusters simply relink the chain.
	task automatic run_chain_sequence();
		logic [11:0] links [9];
		logic [11:0] tail_mark;
		int unsigned len, k;
		len = $urandom_range(1, 8);
		foreach (links[i]) links[i] = pick_cluster();
		if ($urandom_range(0, 3) == 0) tail_mark = 12'($urandom_range(0, 1));
		else tail_mark = 12'($urandom_range(EOC_MIN, ENTRY_MASK));
		for (k = 0; k < len; k++)
			send_request(OP_WRITE_ENTRY, $urandom(), $urandom(), links[k],
				(k == len - 1) ? tail_mark : links[k + 1]);
		if ($urandom_range(0, 1) == 0)
			send_request(OP_READ_ENTRY, $urandom(), $urandom(),
				links[$urandom_range(0, len - 1)], $urandom());
		if ($urandom_range(0, 4) != 0)
			send_request(OP_FREE_CHAIN, $urandom(), $urandom(), links[0], $urandom());
		else
			send_request(OP_FREE_CHAIN, $urandom(), $urandom(),
				links[$urandom_range(0, len - 1)], $urandom());
		if ($urandom_range(0, 1) == 0)
			send_request(OP_READ_ENTRY, $urandom(), $urandom(), links[0], $urandom());
		if ($urandom_range(0, 4) < 2)
			send_request(OP_FIND_FREE, $urandom(), $urandom(), links[len - 1], $urandom());
		chains_built++;
	endtask

	initial begin
		int unsigned ph, quota, phase_base, pick, cc, spc, i;
		logic [15:0] ds;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The table holds nothing defined after reset, so every byte is loaded first,
		// back to back. About two in five bytes are zero so that free entries are common.
		idle_mode = 0;
		for (i = 0; i < TABLE_DEPTH_DEF; i++)
			send_request(OP_LOAD_BYTE, 13'(i),
				($urandom_range(0, 4) < 2) ? 8'h00 : 8'($urandom()), $urandom(), $urandom());

		// Directed part under the reset settings: a zero cluster count means no search
		// range at all and an immediate step limit for any chain start of two or more.
		idle_mode = 1;
		send_request(OP_FIND_FREE, $urandom(), $urandom(), FIRST_CLUSTER, $urandom());
		send_request(OP_FREE_CHAIN, $urandom(), $urandom(), FIRST_CLUSTER, $urandom());
		send_request(OP_FREE_CHAIN, $urandom(), $urandom(), 12'd1, $urandom());
		send_request(OP_READ_ENTRY, $urandom(), $urandom(), 12'd0, $urandom());
		send_request(OP_SPARE_A, $urandom(), $urandom(), $urandom(), $urandom());
		send_request(OP_SPARE_B, $urandom(), $urandom(), $urandom(), $urandom());

		// Extreme settings: largest count, top data start and most sectors per cluster, so
		// sector addresses wrap. The highest odd and even entries and the last byte are hit.
		apply_settings(4084, 16'hFFFF, 128);
		send_request(OP_WRITE_ENTRY, $urandom(), $urandom(), ENTRY_MASK, ENTRY_MASK);
		send_request(OP_READ_ENTRY, $urandom(), $urandom(), ENTRY_MASK, $urandom());
		send_request(OP_WRITE_ENTRY, $urandom(), $urandom(), 12'd4094, 12'd0);
		send_request(OP_READ_BYTE, 13'd6143, $urandom(), $urandom(), $urandom());
		send_request(OP_LOAD_BYTE, 13'd8191, 8'hFF, $urandom(), $urandom());
		send_request(OP_READ_BYTE, 13'd8191, $urandom(), $urandom(), $urandom());
		// A two-entry chain ending on the highest end marker, then one ending on a low link.
		send_request(OP_WRITE_ENTRY, $urandom(), $urandom(), 12'd2, 12'd3);
		send_request(OP_WRITE_ENTRY, $urandom(), $urandom(), 12'd3, ENTRY_MASK);
		send_request(OP_FREE_CHAIN, $urandom(), $urandom(), 12'd2, $urandom());
		send_request(OP_READ_ENTRY, $urandom(), $urandom(), 12'd3, $urandom());
		send_request(OP_WRITE_ENTRY, $urandom(), $urandom(), 12'd5, 12'd1);
		send_request(OP_FREE_CHAIN, $urandom(), $urandom(), 12'd5, $urandom());
		// A search from below two starts at two; one from above the bound only wraps.
		send_request(OP_FIND_FREE, $urandom(), $urandom(), 12'd0, $urandom());
		send_request(OP_FIND_FREE, $urandom(), $urandom(), ENTRY_MASK, $urandom());

		// A chain one entry longer than the cluster count hits the step limit.
		apply_settings(3, 16'h0000, 1);
		for (i = 10; i < 13; i++)
			send_request(OP_WRITE_ENTRY, $urandom(), $urandom(), 12'(i), 12'(i + 1));
		send_request(OP_WRITE_ENTRY, $urandom(), $urandom(), 12'd13, EOC_MIN);
		send_request(OP_FREE_CHAIN, $urandom(), $urandom(), 12'd10, $urandom());

		// Random part. Each phase programs new settings; most use small cluster counts so
		// walks stay short, one uses the largest count with only a few requests.
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			ds = 16'($urandom());
			spc = $urandom_range(1, 128);
			if (ph == 0) begin
				cc = 0;
				ds = 16'h0000;
				spc = 1;
			end else if (ph == 1) begin
				cc = 4084;
			end else if (ph == 2) begin
				cc = 1;
				ds = 16'hFFFF;
				spc = 128;
			end else if ($urandom_range(0, 4) == 0) begin
				cc = $urandom_range(81, 400);
			end else begin
				cc = $urandom_range(2, 80);
			end
			apply_settings(cc, ds, spc);
			quota = (ph == 1) ? 30 : 120;
			idle_mode = $urandom_range(0, 3);
			phase_base = issued;
			while (issued - phase_base < quota) begin
				// Now and then the sender drains the engine completely before going on.
				if ($urandom_range(0, 79) == 0) wait_all_results();
				pick = $urandom_range(0, 99);
				if (pick < 45) begin
					run_chain_sequence();
				end else if (pick < 65) begin
					send_request(OP_FIND_FREE, $urandom(), $urandom(),
						($urandom_range(0, 2) == 0) ? 12'($urandom())
							: 12'($urandom_range(0, cur_count + 3)), $urandom());
				end else if (pick < 75) begin
					send_request(OP_READ_ENTRY, $urandom(), $urandom(),
						($urandom_range(0, 1) == 0) ? pick_cluster() : 12'($urandom()),
						$urandom());
				end else if (pick < 83) begin
					send_request(OP_WRITE_ENTRY, $urandom(), $urandom(), $urandom(),
						($urandom_range(0, 2) == 0) ? 12'd0 : 12'($urandom()));
				end else if (pick < 90) begin
					send_request(OP_LOAD_BYTE, $urandom(), $urandom(), $urandom(), $urandom());
				end else if (pick < 95) begin
					send_request(OP_READ_BYTE, $urandom(), $urandom(), $urandom(), $urandom());
				end else if (pick < 98) begin
					send_request(OP_FREE_CHAIN, $urandom(), $urandom(),
						($urandom_range(0, 1) == 0) ? pick_cluster() : 12'($urandom()),
						$urandom());
				end else begin
					send_request((pick[0]) ? OP_SPARE_A : OP_SPARE_B, $urandom(), $urandom(),
						$urandom(), $urandom());
				end
			end
		end

		// Let the last results arrive, then watch a little longer for stray strobes.
		wait_all_results();
		repeat (20) @(posedge clk);

		$display("Sent %0d requests over %0d register settings: %0d byte loads, %0d byte reads,",
			issued, settings_used, op_tally[OP_LOAD_BYTE], op_tally[OP_READ_BYTE]);
		$display("%0d entry reads, %0d entry writes, %0d searches, %0d chain frees (%0d built).",
			op_tally[OP_READ_ENTRY], op_tally[OP_WRITE_ENTRY], op_tally[OP_FIND_FREE],
			op_tally[OP_FREE_CHAIN], chains_built);
		if (fail_count == 0 && pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
